>>> src/lmsdb_pkg.sv
// shared types and constants for the double buffered led matrix scanner
package lmsdb_pkg;

  localparam int ROW_BITS   = 32;
  localparam int SHIFT_BITS = 16;

  localparam logic [1:0] FLAG_FRAME = 2'b01;
  localparam logic [1:0] FLAG_SLOW  = 2'b10;

  localparam logic [7:0] DIVIDER_RESET = 8'd10;

  typedef logic [ROW_BITS-1:0] row_word_t;

  typedef enum logic [2:0] {
    MODE_TICK       = 3'd0,
    MODE_WRITE      = 3'd1,
    MODE_READ       = 3'd2,
    MODE_FLIP       = 3'd3,
    MODE_READ_FLAGS = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    KIND_SHIFT = 2'd0,
    KIND_PIXEL = 2'd1,
    KIND_FLAGS = 2'd2
  } kind_t;

  typedef enum logic {
    REG_DUAL_PAGE    = 1'b0,
    REG_FLAG_DIVIDER = 1'b1
  } reg_index_t;

endpackage

>>> src/led_matrix_scan_double_buffer.sv
// led matrix scanner top level: frame store, scan control and result sequencing
// the first result appears in the cycle that follows the accepting edge
// a tick gives sixteen results in consecutive cycles and holds busy until its last
// result, so a new tick can be accepted during that result, bounded by the serial shift of one row
// every other mode does not raise busy and may be followed in the next cycle
// synchronous reset clears row valid flags, so the frame store reads as zero at once
module led_matrix_scan_double_buffer #(
  parameter int ROWS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] mode,
  input  logic [4:0] pixel_x,
  input  logic [3:0] pixel_y,
  input  logic       pixel_on,
  output logic       strobe,
  output logic [1:0] kind,
  output logic       row_bit,
  output logic       left_bit,
  output logic       right_bit,
  output logic       latch,
  output logic       pixel_value,
  output logic [1:0] period_flags,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);
  import lmsdb_pkg::*;

  localparam int RW    = $clog2(ROWS);
  localparam int AW    = RW + 1;
  localparam int DEPTH = 2 ** AW;
  localparam int CW    = (RW > 4) ? RW : 4;

  // frame store: one 32 bit word per page and row, left half in the low bits
  row_word_t        mem [DEPTH];
  logic [DEPTH-1:0] row_valid;

  logic          dual_page;
  logic [7:0]    flag_divider;
  logic          display_page;
  logic          flip_pending;
  logic [RW-1:0] scan_row;
  logic [7:0]    tick_count;
  logic [1:0]    period_now;
  logic [1:0]    period_seen;

  // result side
  logic          active;
  logic [3:0]    cnt;
  logic [RW-1:0] row_q;
  row_word_t     rd_raw;
  logic          rd_ok;
  logic          single_valid;
  kind_t         single_kind;
  logic [1:0]    single_flags;
  logic [4:0]    col_q;

  logic          accept;
  logic          work_page;
  logic [RW-1:0] y_row;
  logic          y_in_range;
  logic [4:0]    col_bit;
  logic          wr_en;
  logic          rd_en;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic [7:0]    tick_count_next;
  logic          slow_hit;
  logic          row_wrap;
  row_word_t     rd_word;

  assign cfg_ready  = 1'b1;
  assign busy       = active && (cnt != 4'(SHIFT_BITS - 1));
  assign accept     = start && !busy;
  assign work_page  = display_page ^ dual_page;
  assign y_row      = RW'(pixel_y);
  assign y_in_range = (int'(pixel_y) < ROWS);
  // column x maps to bit 15-(x mod 16) of the half word that x[4] selects
  assign col_bit    = {pixel_x[4], ~pixel_x[3:0]};

  assign wr_en = accept && (mode == MODE_WRITE) && y_in_range;
  assign rd_en = accept && ((mode == MODE_TICK) || (mode == MODE_READ));
  assign waddr = {work_page, y_row};
  assign raddr = (mode == MODE_TICK) ? {display_page, scan_row} : {work_page, y_row};

  assign tick_count_next = tick_count + 8'd1;
  assign slow_hit        = (tick_count_next >= flag_divider);
  assign row_wrap        = (int'(scan_row) == ROWS - 1);

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      if (row_valid[waddr]) begin
        mem[waddr][col_bit] <= pixel_on;
      end else begin
        // first write to a row: the rest of the row is still zero
        mem[waddr] <= row_word_t'(pixel_on) << col_bit;
      end
    end
    if (rd_en) begin
      rd_raw <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_ok     <= 1'b0;
    end else begin
      if (wr_en) begin
        row_valid[waddr] <= 1'b1;
      end
      if (rd_en) begin
        rd_ok <= row_valid[raddr] && ((mode == MODE_TICK) || y_in_range);
      end
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      dual_page    <= 1'b0;
      flag_divider <= DIVIDER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DUAL_PAGE:    dual_page    <= cfg_data[0];
        REG_FLAG_DIVIDER: flag_divider <= cfg_data;
        default: ;
      endcase
    end
  end

  // scan and page state
  always_ff @(posedge clk) begin
    if (rst) begin
      display_page <= 1'b0;
      flip_pending <= 1'b0;
      scan_row     <= '0;
      tick_count   <= '0;
      period_now   <= '0;
      period_seen  <= '0;
    end else if (accept) begin
      case (mode)
        MODE_TICK: begin
          tick_count <= slow_hit ? 8'd0 : tick_count_next;
          period_now <= (slow_hit ? FLAG_SLOW : 2'b00) | (row_wrap ? FLAG_FRAME : 2'b00);
          if (row_wrap) begin
            scan_row <= '0;
            if (flip_pending && dual_page) begin
              flip_pending <= 1'b0;
              display_page <= ~display_page;
            end
          end else begin
            scan_row <= scan_row + RW'(1);
          end
        end
        MODE_FLIP: begin
          if (dual_page) begin
            flip_pending <= 1'b1;
          end
        end
        MODE_READ_FLAGS: begin
          period_seen <= period_now;
        end
        default: ;
      endcase
    end
  end

  // result sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= 1'b0;
      cnt          <= '0;
      single_valid <= 1'b0;
    end else begin
      single_valid <= accept && ((mode == MODE_READ) || (mode == MODE_READ_FLAGS));
      if (accept && (mode == MODE_TICK)) begin
        active <= 1'b1;
        cnt    <= '0;
      end else if (active) begin
        cnt <= cnt + 4'd1;
        if (cnt == 4'(SHIFT_BITS - 1)) begin
          active <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      row_q        <= scan_row;
      col_q        <= col_bit;
      single_kind  <= (mode == MODE_READ) ? KIND_PIXEL : KIND_FLAGS;
      single_flags <= period_now & ~period_seen;
    end
  end

  assign rd_word = rd_ok ? rd_raw : '0;

  always_comb begin
    strobe       = active || single_valid;
    kind         = KIND_SHIFT;
    row_bit      = 1'b0;
    left_bit     = 1'b0;
    right_bit    = 1'b0;
    latch        = 1'b0;
    pixel_value  = 1'b0;
    period_flags = 2'b00;
    if (active) begin
      row_bit   = (CW'(row_q) == CW'(cnt));
      left_bit  = rd_word[{1'b0, cnt}];
      right_bit = rd_word[{1'b1, cnt}];
      latch     = (cnt == 4'(SHIFT_BITS - 1));
    end else if (single_valid) begin
      kind = single_kind;
      if (single_kind == KIND_PIXEL) begin
        pixel_value = rd_word[col_q];
      end else begin
        period_flags = single_flags;
      end
    end
  end

endmodule
